FILE: hdl/ntc_pkg.sv
`timescale 1ns / 1ps

package ntc_pkg;

    // Field widths
    localparam int IDX_W    = 8;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = SAMPLE_W + 2;
    localparam int TEMP_W   = 9;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int TABLE_DEPTH = 256;

    // Request codes
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NORMAL = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OPEN   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_TOP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd3;

    // Config reset values
    localparam logic [IDX_W-1:0]    SEARCH_TOP_RST  = 8'd159;
    localparam logic                FAULT_EN_RST    = 1'b0;
    localparam logic [SAMPLE_W-1:0] OPEN_LIMIT_RST  = 12'd4087;
    localparam logic [SAMPLE_W-1:0] SHORT_LIMIT_RST = 12'd368;

    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 9'd40;
    localparam logic [TEMP_W-1:0] TEMP_OPEN   = 9'd0;
    localparam logic [TEMP_W-1:0] TEMP_SHORT  = 9'd1;

    // Controller -> datapath
    typedef struct packed {
        logic                wr;
        logic                load;
        logic                step;
        logic                set_st;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_open;
        logic is_short;
        logic stop;
    } t_dp_stat;

endpackage

FILE: hdl/ntc_if.sv
`timescale 1ns / 1ps

interface ntc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [ntc_pkg::IDX_W-1:0]         entry_index;
    logic [ntc_pkg::SAMPLE_W-1:0]      entry_value;
    logic [ntc_pkg::SAMPLE_W-1:0]      sample_a;
    logic [ntc_pkg::SAMPLE_W-1:0]      sample_b;
    logic [ntc_pkg::SAMPLE_W-1:0]      sample_c;
    logic [ntc_pkg::SAMPLE_W-1:0]      sample_d;

    modport source (output valid, req_type, entry_index, entry_value,
                    sample_a, sample_b, sample_c, sample_d, input ready);
    modport sink   (input valid, req_type, entry_index, entry_value,
                    sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

interface ntc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ntc_pkg::TEMP_W-1:0]  temperature;
    logic [ntc_pkg::STATUS_W-1:0]       status;
    logic [ntc_pkg::SAMPLE_W-1:0]       average;

    modport source (output valid, temperature, status, average, input ready);
    modport sink   (input valid, temperature, status, average, output ready);
endinterface

interface ntc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ntc_pkg::CFG_IDX_W-1:0]      index;
    logic [ntc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/ntc_ram.sv
`timescale 1ns / 1ps

module ntc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ntc_ctrl.sv
`timescale 1ns / 1ps

module ntc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_req_type,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  ntc_pkg::t_dp_stat   i_stat,
    output ntc_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.st_code = ntc_pkg::ST_NORMAL;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr   = accept && (i_req_type == ntc_pkg::REQ_WRITE);
                o_cmd.load = accept && (i_req_type == ntc_pkg::REQ_CONVERT);
                if (o_cmd.load) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // fault screen; first table read is issued this cycle
                if (i_stat.is_open) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ntc_pkg::ST_OPEN;
                    n_state       = S_DONE;
                end else if (i_stat.is_short) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ntc_pkg::ST_SHORT;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.stop) begin
                    o_cmd.set_st = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/ntc_dp.sv
`timescale 1ns / 1ps

module ntc_dp #(
    parameter int TABLE_DEPTH = ntc_pkg::TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [ntc_pkg::IDX_W-1:0]           i_entry_index,
    input  logic [ntc_pkg::SAMPLE_W-1:0]        i_entry_value,
    input  logic [ntc_pkg::SAMPLE_W-1:0]        i_sample_a,
    input  logic [ntc_pkg::SAMPLE_W-1:0]        i_sample_b,
    input  logic [ntc_pkg::SAMPLE_W-1:0]        i_sample_c,
    input  logic [ntc_pkg::SAMPLE_W-1:0]        i_sample_d,
    input  ntc_pkg::t_dp_cmd                    i_cmd,
    output ntc_pkg::t_dp_stat                   o_stat,
    output logic signed [ntc_pkg::TEMP_W-1:0]   o_temperature,
    output logic [ntc_pkg::STATUS_W-1:0]        o_status,
    output logic [ntc_pkg::SAMPLE_W-1:0]        o_average
);

    localparam int IW = ntc_pkg::IDX_W;
    localparam int SW = ntc_pkg::SAMPLE_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW > IW) ? AW : IW;

    // config registers
    logic [IW-1:0] r_search_top;
    logic          r_fault_en;
    logic [SW-1:0] r_open_limit;
    logic [SW-1:0] r_short_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_top  <= ntc_pkg::SEARCH_TOP_RST;
            r_fault_en    <= ntc_pkg::FAULT_EN_RST;
            r_open_limit  <= ntc_pkg::OPEN_LIMIT_RST;
            r_short_limit <= ntc_pkg::SHORT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ntc_pkg::REG_SEARCH_TOP:  r_search_top  <= i_cfg_data[IW-1:0];
                ntc_pkg::REG_FAULT_EN:    r_fault_en    <= i_cfg_data[0];
                ntc_pkg::REG_OPEN_LIMIT:  r_open_limit  <= i_cfg_data[SW-1:0];
                ntc_pkg::REG_SHORT_LIMIT: r_short_limit <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // search registers
    logic [SW-1:0]               r_avg;
    logic [IW-1:0]               r_high, r_low, r_mid;
    logic                        r_rd_oor;
    logic [ntc_pkg::STATUS_W-1:0] r_st;
    logic [ntc_pkg::SUM_W-1:0]   sum;

    assign sum = ntc_pkg::SUM_W'(i_sample_a) + ntc_pkg::SUM_W'(i_sample_b)
               + ntc_pkg::SUM_W'(i_sample_c) + ntc_pkg::SUM_W'(i_sample_d);

    // table memory
    logic [SW-1:0] rdata, entry;
    logic [CW-1:0] wr_ext, rd_ext;
    logic [IW-1:0] rd_mid, n_high, n_low, n_mid;
    logic [IW:0]   mid_sum;
    logic          wr_ok, rd_ok, gt, lt;

    assign wr_ext = CW'(i_entry_index);
    assign wr_ok  = (32'(i_entry_index) < 32'(TABLE_DEPTH));

    ntc_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr && wr_ok),
        .i_waddr (wr_ext[AW-1:0]),
        .i_wdata (i_entry_value),
        .i_raddr (rd_ext[AW-1:0]),
        .o_rdata (rdata)
    );

    // probe out of table range reads as zero
    assign entry = r_rd_oor ? '0 : rdata;
    assign gt    = (r_avg > entry);
    assign lt    = (r_avg < entry);

    assign n_high  = gt ? r_mid : r_high;
    assign n_low   = lt ? r_mid : r_low;
    assign mid_sum = {1'b0, n_high} + {1'b0, n_low};
    assign n_mid   = mid_sum[IW:1];

    // next probe address goes straight to the RAM while stepping
    assign rd_mid = i_cmd.step ? n_mid : r_mid;
    assign rd_ext = CW'(rd_mid);
    assign rd_ok  = (32'(rd_mid) < 32'(TABLE_DEPTH));

    assign o_stat.is_open  = r_fault_en && (r_avg > r_open_limit);
    assign o_stat.is_short = r_fault_en && (r_avg < r_short_limit);
    assign o_stat.stop     = (!gt && !lt)
                           || ({1'b0, n_high} <= ({1'b0, n_low} + (IW+1)'(1)));

    always_ff @(posedge i_clk) begin
        r_rd_oor <= !rd_ok;
        if (i_cmd.load) begin
            r_avg  <= sum[ntc_pkg::SUM_W-1:2];
            r_high <= r_search_top;
            r_low  <= '0;
            r_mid  <= {1'b0, r_search_top[IW-1:1]};
        end else if (i_cmd.step) begin
            r_high <= n_high;
            r_low  <= n_low;
            r_mid  <= n_mid;
        end
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st_code;
        end
    end

    // result register
    logic [ntc_pkg::TEMP_W-1:0]   r_temp_o, temp_c;
    logic [ntc_pkg::STATUS_W-1:0] r_st_o;
    logic [SW-1:0]                r_avg_o;

    always_comb begin
        unique case (r_st)
            ntc_pkg::ST_OPEN:  temp_c = ntc_pkg::TEMP_OPEN;
            ntc_pkg::ST_SHORT: temp_c = ntc_pkg::TEMP_SHORT;
            default:           temp_c = {1'b0, r_mid} - ntc_pkg::TEMP_OFFSET;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_temp_o <= temp_c;
            r_st_o   <= r_st;
            r_avg_o  <= r_avg;
        end
    end

    assign o_temperature = $signed(r_temp_o);
    assign o_status      = r_st_o;
    assign o_average     = r_avg_o;

endmodule

FILE: hdl/ntc_table_temperature_search.sv
`timescale 1ns / 1ps

// Thermistor ADC to temperature converter.
// i_in (sink): one word per request. req_type write stores entry_value at
//   entry_index in the calibration table (descending ADC codes); accepted in
//   the idle state, no result. req_type convert averages sample_a..sample_d
//   ((a+b+c+d)>>2) and returns one result word.
// o_out (source): temperature (probe index - 40, 0 on open, 1 on short),
//   status (normal/open/short) and the average.
// i_cfg (sink): register writes, always ready; write only while idle.
//   0 search_top, 1 fault_check_enable, 2 open_limit, 3 short_limit.
// Sequence: a convert averages into the search registers when accepted,
//   then screens for faults while issuing the first table read, then runs
//   the search probes (the single table read port sets the pace: probe,
//   compare and next address in one loop), then loads the result register.
//   A fault result skips the probes.
//   One convert is in flight at a time; i_in.ready is low meanwhile.
// Stall: the result holds in its output register; the next word is taken
//   while it waits, and a further result waits until it is taken.
// Reset: control and config registers go to their defaults; table contents
//   are undefined until written.
module ntc_table_temperature_search #(
    parameter int TABLE_DEPTH = ntc_pkg::TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ntc_in_if.sink    i_in,
    ntc_out_if.source o_out,
    ntc_cfg_if.sink   i_cfg
);

    ntc_pkg::t_dp_cmd  cmd;
    ntc_pkg::t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    // sequencer: accept, fault screen, probe loop, result load
    ntc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_req_type  (i_in.req_type),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // config, averaging, table RAM, search registers, result register
    ntc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_idx     (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_entry_index (i_in.entry_index),
        .i_entry_value (i_in.entry_value),
        .i_sample_a    (i_in.sample_a),
        .i_sample_b    (i_in.sample_b),
        .i_sample_c    (i_in.sample_c),
        .i_sample_d    (i_in.sample_d),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_temperature (o_out.temperature),
        .o_status      (o_out.status),
        .o_average     (o_out.average)
    );

    // a convert blocks further input until its result is loaded
    a_convert_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.req_type == ntc_pkg::REQ_CONVERT))
        |=> !i_in.ready && !$rose(o_out.valid))
        else $error("input taken during convert");

    // fault results carry their fixed temperature codes
    a_open_temp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ntc_pkg::ST_OPEN))
        |-> (o_out.temperature == ntc_pkg::TEMP_OPEN))
        else $error("open result temperature wrong");

    a_short_temp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ntc_pkg::ST_SHORT))
        |-> (o_out.temperature == ntc_pkg::TEMP_SHORT))
        else $error("short result temperature wrong");

    // status is always one of the defined codes
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.status == ntc_pkg::ST_NORMAL)
                      || (o_out.status == ntc_pkg::ST_OPEN)
                      || (o_out.status == ntc_pkg::ST_SHORT)))
        else $error("bad status code");

endmodule

FILE: tb/ntc_table_temperature_search_tb.sv
`timescale 1ns / 1ps

module ntc_table_temperature_search_tb;
    import ntc_pkg::*;

    localparam int RST_CYCLES   = 6;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
    localparam int STALL_LIMIT  = 5000;  // cycles with no accepted word at all
    localparam int BLOCK_WORDS  = 40;

    // One input word as the block sees it
    typedef struct packed {
        logic                req_type;
        logic [IDX_W-1:0]    entry_index;
        logic [SAMPLE_W-1:0] entry_value;
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic [SAMPLE_W-1:0] sample_c;
        logic [SAMPLE_W-1:0] sample_d;
    } t_ntc_word;

    // One result word
    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [STATUS_W-1:0]      status;
        logic [SAMPLE_W-1:0]      average;
    } t_reading;

    // Keeps its own copy of the calibration table and the settings, works out
    // the reading of each accepted convert word and checks returned readings
    // in order.
    class reading_scoreboard;
        logic [SAMPLE_W-1:0] cal_table [TABLE_DEPTH];
        logic [IDX_W-1:0]    search_top;
        logic                fault_en;
        logic [SAMPLE_W-1:0] open_limit;
        logic [SAMPLE_W-1:0] short_limit;
        t_reading            readings_due [$];
        int                  errors;

        function new();
            search_top  = SEARCH_TOP_RST;
            fault_en    = FAULT_EN_RST;
            open_limit  = OPEN_LIMIT_RST;
            short_limit = SHORT_LIMIT_RST;
            errors      = 0;
            foreach (cal_table[i]) cal_table[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEARCH_TOP:  search_top  = data[IDX_W-1:0];
                REG_FAULT_EN:    fault_en    = data[0];
                REG_OPEN_LIMIT:  open_limit  = data[SAMPLE_W-1:0];
                REG_SHORT_LIMIT: short_limit = data[SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Index where the halving search over the descending table settles.
        function int unsigned settle_index(logic [SAMPLE_W-1:0] avg);
            int unsigned         hi;
            int unsigned         lo;
            int unsigned         mid;
            logic [SAMPLE_W-1:0] entry;
            hi  = 32'(search_top);
            lo  = 0;
            mid = 0;
            while (1) begin
                mid   = (hi + lo) >> 1;
                entry = (mid < TABLE_DEPTH) ? cal_table[IDX_W'(mid)] : '0;
                if (avg > entry)
                    hi = mid;
                else if (avg < entry)
                    lo = mid;
                else
                    break;
                // top of 0 or 1 also ends here after one probe
                if (hi <= lo + 1)
                    break;
            end
            return mid;
        endfunction

        function void note_word(t_ntc_word w);
            logic [SUM_W-1:0] sum;
            t_reading         r;
            if (w.req_type == REQ_WRITE) begin
                if (w.entry_index < TABLE_DEPTH)
                    cal_table[w.entry_index] = w.entry_value;
            end else begin
                sum = SUM_W'(w.sample_a) + SUM_W'(w.sample_b)
                    + SUM_W'(w.sample_c) + SUM_W'(w.sample_d);
                r.average = sum[SUM_W-1:2];
                // open wins when both limits are crossed
                if (fault_en && r.average > open_limit) begin
                    r.temperature = TEMP_OPEN;
                    r.status      = ST_OPEN;
                end else if (fault_en && r.average < short_limit) begin
                    r.temperature = TEMP_SHORT;
                    r.status      = ST_SHORT;
                end else begin
                    r.temperature = TEMP_W'(settle_index(r.average)) - TEMP_OFFSET;
                    r.status      = ST_NORMAL;
                end
                readings_due.push_back(r);
            end
        endfunction

        function void note_mismatch(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field, want, got);
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (readings_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none actual %s",
                         $time, "word");
                $display("%0t: actual temp %0d status %0d avg %0d",
                         $time, $signed(got.temperature), got.status, got.average);
            end else begin
                want = readings_due.pop_front();
                if (got.temperature !== want.temperature)
                    note_mismatch("temperature", int'($signed(want.temperature)),
                                  int'($signed(got.temperature)));
                if (got.status !== want.status)
                    note_mismatch("status", int'(want.status), int'(got.status));
                if (got.average !== want.average)
                    note_mismatch("average", int'(want.average), int'(got.average));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ntc_in_if  in_bus ();
    ntc_out_if out_bus ();
    ntc_cfg_if cfg_bus ();

    ntc_table_temperature_search i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    reading_scoreboard sb = new();

    // per-cycle idle odds in percent; changed per phase by the main sequence
    int in_idle_pct  = 23;
    int out_idle_pct = 45;
    // main sequence asks for one long receiver hold-off
    bit hold_req     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check every accepted word, then pick ready for the next
    // edge. A hold-off request keeps ready low for HOLD_CYCLES, counted here,
    // so the block fills up and must stall its input.
    initial begin
        int hold_left;
        hold_left = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_bus.valid && out_bus.ready)
                sb.check_reading({out_bus.temperature, out_bus.status, out_bus.average});
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (!i_rst_n) begin
                out_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on any channel
    // means the block has hung (or lost a result).
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one word after a random gap; valid stays high after acceptance
    // so back-to-back words need no extra cycle.
    task automatic send_word(t_ntc_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.req_type    <= w.req_type;
        in_bus.entry_index <= w.entry_index;
        in_bus.entry_value <= w.entry_value;
        in_bus.sample_a    <= w.sample_a;
        in_bus.sample_b    <= w.sample_b;
        in_bus.sample_c    <= w.sample_c;
        in_bus.sample_d    <= w.sample_d;
        do @(posedge i_clk); while (!(in_bus.valid && in_bus.ready));
        sb.note_word(w);
    endtask

    // unused fields carry random bits so every input bit toggles
    task automatic send_convert(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
        t_ntc_word w;
        w.req_type    = REQ_CONVERT;
        w.entry_index = IDX_W'($urandom);
        w.entry_value = SAMPLE_W'($urandom);
        w.sample_a    = a;
        w.sample_b    = b;
        w.sample_c    = c;
        w.sample_d    = d;
        send_word(w);
    endtask

    task automatic send_entry(logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
        t_ntc_word w;
        w.req_type    = REQ_WRITE;
        w.entry_index = idx;
        w.entry_value = value;
        w.sample_a    = SAMPLE_W'($urandom);
        w.sample_b    = SAMPLE_W'($urandom);
        w.sample_c    = SAMPLE_W'($urandom);
        w.sample_d    = SAMPLE_W'($urandom);
        send_word(w);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        sb.set_reg(idx, data);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, let every expected reading come back, then give a
    // trailing write time to land before the next register write.
    task automatic drain_readings();
        in_bus.valid <= 1'b0;
        while (sb.readings_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [IDX_W-1:0] top, logic fault_on,
                                  logic [SAMPLE_W-1:0] open_lim,
                                  logic [SAMPLE_W-1:0] short_lim);
        drain_readings();
        write_reg(REG_SEARCH_TOP, CFG_DATA_W'(top));
        write_reg(REG_FAULT_EN, CFG_DATA_W'(fault_on));
        write_reg(REG_OPEN_LIMIT, open_lim);
        write_reg(REG_SHORT_LIMIT, short_lim);
    endtask

    task automatic random_settings();
        logic [IDX_W-1:0]    top;
        logic                fault_on;
        logic [SAMPLE_W-1:0] open_lim;
        logic [SAMPLE_W-1:0] short_lim;
        case ($urandom_range(0, 4))
            0:       top = SEARCH_TOP_RST;
            1:       top = 8'd240;
            2:       top = 8'd255;
            default: top = IDX_W'($urandom_range(1, 254));
        endcase
        fault_on  = 1'($urandom_range(0, 1));
        open_lim  = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(3500, 4095))
                                         : SAMPLE_W'($urandom_range(0, 4095));
        short_lim = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 800))
                                         : SAMPLE_W'($urandom_range(0, 4095));
        apply_settings(top, fault_on, open_lim, short_lim);
    endtask

    // Fill every entry with a descending curve of random slope. Every entry
    // is written, so no search can ever land on an unwritten one.
    task automatic load_table(bit pin_ends);
        int v;
        int dip;
        v = pin_ends ? 4095 : 4095 - $urandom_range(0, 60);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_entry(IDX_W'(i),
                       SAMPLE_W'((pin_ends && i == TABLE_DEPTH - 1) ? 0 : v));
            dip = $urandom_range(0, 30);
            v   = (v > dip) ? v - dip : 0;
        end
    endtask

    // Mostly converts (5 in 13 of them aimed right at a table entry) and
    // curve-preserving rewrites; some raw writes that break monotonicity.
    task automatic random_block(int n_words);
        int                  pick;
        int                  target;
        int                  spread;
        int                  idx;
        logic [SAMPLE_W-1:0] hi_b;
        logic [SAMPLE_W-1:0] lo_b;
        repeat (n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_convert(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                             SAMPLE_W'($urandom), SAMPLE_W'($urandom));
            end else if (pick < 65) begin
                target = int'(sb.cal_table[IDX_W'($urandom_range(0, TABLE_DEPTH - 1))]);
                spread = (target >= 3 && target <= 4092) ? $urandom_range(0, 3) : 0;
                // extra stays under 4 so the average is exactly the entry
                send_convert(SAMPLE_W'(target + spread), SAMPLE_W'(target - spread),
                             SAMPLE_W'(target),
                             SAMPLE_W'(target + ((target <= 4092) ? $urandom_range(0, 3) : 0)));
            end else if (pick < 90) begin
                idx  = $urandom_range(0, TABLE_DEPTH - 1);
                hi_b = (idx == 0) ? 12'hFFF : sb.cal_table[IDX_W'(idx - 1)];
                lo_b = (idx == TABLE_DEPTH - 1) ? 12'h000 : sb.cal_table[IDX_W'(idx + 1)];
                send_entry(IDX_W'(idx), SAMPLE_W'($urandom_range(hi_b, lo_b)));
            end else begin
                send_entry(IDX_W'($urandom), SAMPLE_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [SAMPLE_W-1:0] t;
        i_rst_n             <= 1'b0;
        in_bus.valid        <= 1'b0;
        in_bus.req_type     <= REQ_WRITE;
        in_bus.entry_index  <= '0;
        in_bus.entry_value  <= '0;
        in_bus.sample_a     <= '0;
        in_bus.sample_b     <= '0;
        in_bus.sample_c     <= '0;
        in_bus.sample_d     <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= REG_SEARCH_TOP;
        cfg_bus.data        <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 1: sender idles 23%, receiver 45%
        in_idle_pct  = 23;
        out_idle_pct = 45;
        load_table(1'b1);

        // Reset settings: board table top, fault checks off
        send_convert(12'd0, 12'd0, 12'd0, 12'd0);                // average floor
        send_convert(12'd4095, 12'd4095, 12'd4095, 12'd4095);    // average ceiling
        send_convert(12'd1, 12'd2, 12'd3, 12'd4);                // sum remainder drops
        send_convert(12'hAAA, 12'h555, 12'hAAA, 12'h555);
        t = sb.cal_table[8'd79];                                 // exact hit, first probe
        send_convert(t, t, t, t);
        t = sb.cal_table[8'd159];
        send_convert(t, t, t, t);

        // Fault checks on at reset limits: both sides of each limit
        apply_settings(SEARCH_TOP_RST, 1'b1, OPEN_LIMIT_RST, SHORT_LIMIT_RST);
        send_convert(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_convert(12'd4088, 12'd4088, 12'd4088, 12'd4088);
        send_convert(12'd4087, 12'd4087, 12'd4087, 12'd4087);
        send_convert(12'd368, 12'd368, 12'd368, 12'd368);
        send_convert(12'd367, 12'd367, 12'd367, 12'd367);
        send_convert(12'd0, 12'd0, 12'd0, 12'd0);

        // Crossed limits: both faults hold, open is reported
        apply_settings(SEARCH_TOP_RST, 1'b1, 12'd100, 12'd4000);
        send_convert(12'd2000, 12'd2000, 12'd2000, 12'd2000);

        // Widest search, checks on but unreachable
        apply_settings(8'd255, 1'b1, 12'hFFF, 12'h000);
        send_convert(12'd0, 12'd0, 12'd0, 12'd0);
        t = sb.cal_table[8'd254];
        send_convert(t, t, t, t);

        // Tiny tops: a single probe
        apply_settings(8'd1, 1'b0, OPEN_LIMIT_RST, SHORT_LIMIT_RST);
        send_convert(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_convert(12'd0, 12'd0, 12'd0, 12'd0);
        apply_settings(8'd0, 1'b0, OPEN_LIMIT_RST, SHORT_LIMIT_RST);
        send_convert(12'd2048, 12'd2048, 12'd2048, 12'd2048);

        // Stator top, limits at the opposite extremes
        apply_settings(8'd240, 1'b1, 12'h000, 12'hFFF);
        send_convert(12'd0, 12'd0, 12'd0, 12'd0);
        send_convert(12'd1, 12'd1, 12'd1, 12'd1);

        for (int blk = 0; blk < 3; blk++) begin
            random_settings();
            random_block(BLOCK_WORDS);
        end

        // Phase 2: sender idles 45%, receiver 23%; one long hold-off while
        // the sender keeps offering
        drain_readings();
        in_idle_pct  = 45;
        out_idle_pct = 23;
        for (int blk = 0; blk < 3; blk++) begin
            random_settings();
            if (blk == 0)
                hold_req = 1'b1;
            random_block(BLOCK_WORDS);
        end

        // Phase 3: no idling on either side, fresh curve
        drain_readings();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        load_table(1'b0);
        for (int blk = 0; blk < 3; blk++) begin
            random_settings();
            random_block(BLOCK_WORDS);
        end

        drain_readings();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
